[rtl/pgge_pkg.sv]
// ----------------------------------------------------------------------------
// pgge_pkg
// Shared types and codes for the privilege grant graph engine: request
// actions and the operation codes of the shared matrix unit.
// ----------------------------------------------------------------------------
package pgge_pkg;

    // Request actions
    localparam logic [1:0] ACT_CHECK      = 2'd0;
    localparam logic [1:0] ACT_GRANT      = 2'd1;
    localparam logic [1:0] ACT_REVOKE     = 2'd2;
    localparam logic [1:0] ACT_REVOKE_ALL = 2'd3;

    // Matrix unit operations
    typedef logic [2:0] op_t;

    localparam op_t OP_NONE  = 3'd0;  // pass matrix through
    localparam op_t OP_COL   = 3'd1;  // flag: column has any grantor
    localparam op_t OP_ADD   = 3'd2;  // OR mask into one row
    localparam op_t OP_CLOSE = 3'd3;  // one Warshall pass on pivot
    localparam op_t OP_DIAG  = 3'd4;  // flag: any diagonal bit set
    localparam op_t OP_EDGE  = 3'd5;  // flag: edge present, clear it
    localparam op_t OP_CASC  = 3'd6;  // one cascade step

endpackage

[rtl/privilege_grant_graph_engine_unit.sv]
// Owner check, invalid actor or request with no work goes straight to done;
// check visits each privilege in turn; grant adds, closes and tests each
// selected privilege; revoke visits target/privilege edges, with cascade
// steps after each removed edge. A new transaction is accepted only when
// idle again after done; done is a one-cycle strobe the receiver cannot stall.
// Reset clears all grants, owner is 0.
// ----------------------------------------------------------------------------
// privilege_grant_graph_engine_unit
// Per-privilege grant matrices with check, cycle-safe grant, cascading
// revoke and revoke-all, sequenced over one shared matrix unit.
// ----------------------------------------------------------------------------
module privilege_grant_graph_engine_unit
    import pgge_pkg::*;
#(
    parameter int USERS      = 4,
    parameter int PRIVILEGES = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] owner_user,
    // request
    input  logic       start,
    output logic       busy,
    input  logic [1:0] action,
    input  logic [1:0] actor_user,
    input  logic [3:0] privilege_mask,
    input  logic [3:0] target_mask,
    // result
    output logic       done,
    output logic       success,
    output logic [3:0] held_mask
);

    localparam int UW = $clog2(USERS);
    localparam int PW = (PRIVILEGES > 1) ? $clog2(PRIVILEGES) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_GADD   = 3'd2;
    localparam logic [2:0] S_GCLOSE = 3'd3;
    localparam logic [2:0] S_GDIAG  = 3'd4;
    localparam logic [2:0] S_REDGE  = 3'd5;
    localparam logic [2:0] S_RCASC  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    typedef logic [USERS-1:0][USERS-1:0] mat_t;

    logic [2:0]                     state_reg, state_next;
    logic [1:0]                     owner_reg, owner_next;
    logic [PRIVILEGES-1:0][USERS-1:0][USERS-1:0] grant_reg, grant_next;
    logic [PRIVILEGES-1:0][USERS-1:0][USERS-1:0] work_reg, work_next;
    mat_t                           clo_reg, clo_next;
    logic [1:0]                     action_reg, action_next;
    logic [UW-1:0]                  actor_reg, actor_next;
    logic [PRIVILEGES-1:0]          privs_reg, privs_next;
    logic [USERS-1:0]               tgts_reg, tgts_next;
    logic [PW-1:0]                  p_reg, p_next;
    logic [UW-1:0]                  t_reg, t_next;
    logic [UW-1:0]                  k_reg, k_next;
    logic [USERS-1:0]               pend_reg, pend_next;
    logic                           ok_reg, ok_next;
    logic [PRIVILEGES-1:0]          held_reg, held_next;

    // shared unit hookup
    op_t                            u_op;
    mat_t                           u_mat_in, u_mat_out;
    logic [UW-1:0]                  u_row, u_col;
    logic [USERS-1:0]               u_pend_out;
    logic                           u_flag;

    logic                           actor_ok_in;
    logic [PRIVILEGES-1:0]          privs_in;
    logic [USERS-1:0]               tgts_in;
    logic                           last_p;
    logic                           last_t;

    assign actor_ok_in = (int'(actor_user) < USERS);
    assign privs_in    = PRIVILEGES'(privilege_mask);
    assign tgts_in     = USERS'(target_mask);
    assign last_p      = (p_reg == PW'(PRIVILEGES - 1));
    assign last_t      = (t_reg == UW'(USERS - 1));

    pgge_mat_unit #(
        .USERS (USERS)
    ) u_mat (
        .op          (u_op),
        .mat_in      (u_mat_in),
        .row_sel     (u_row),
        .col_sel     (u_col),
        .mask        (tgts_reg),
        .pending_in  (pend_reg),
        .mat_out     (u_mat_out),
        .pending_out (u_pend_out),
        .flag        (u_flag)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        grant_next  = grant_reg;
        work_next   = work_reg;
        clo_next    = clo_reg;
        action_next = action_reg;
        actor_next  = actor_reg;
        privs_next  = privs_reg;
        tgts_next   = tgts_reg;
        p_next      = p_reg;
        t_next      = t_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        ok_next     = ok_reg;
        held_next   = held_reg;

        u_op     = OP_NONE;
        u_mat_in = work_reg[p_reg];
        u_row    = actor_reg;
        u_col    = actor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    actor_next  = UW'(actor_user);
                    privs_next  = privs_in;
                    tgts_next   = tgts_in;
                    work_next   = grant_reg;
                    p_next      = '0;
                    t_next      = '0;
                    k_next      = '0;
                    ok_next     = 1'b1;
                    held_next   = '0;
                    case (action)
                        ACT_CHECK:
                        begin
                            if (actor_user == owner_reg)
                            begin
                                held_next  = '1;
                                state_next = S_DONE;
                            end
                            else if (!actor_ok_in)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CHECK;
                            end
                        end
                        ACT_GRANT, ACT_REVOKE:
                        begin
                            if (privs_in == '0 || tgts_in == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else if (!actor_ok_in)
                            begin
                                ok_next    = 1'b0;
                                state_next = S_DONE;
                            end
                            else if (action == ACT_GRANT)
                            begin
                                state_next = S_GADD;
                            end
                            else
                            begin
                                state_next = S_REDGE;
                            end
                        end
                        default:
                        begin
                            // revoke all covers every privilege
                            privs_next = '1;
                            state_next = actor_ok_in ? S_REDGE : S_DONE;
                        end
                    endcase
                end
            end

            // one privilege column per cycle
            S_CHECK:
            begin
                u_op             = OP_COL;
                held_next[p_reg] = u_flag;
                if (last_p)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end

            // add actor -> targets, then close on a scratch copy
            S_GADD:
            begin
                if (privs_reg[p_reg])
                begin
                    u_op             = OP_ADD;
                    work_next[p_reg] = u_mat_out;
                    clo_next         = u_mat_out;
                    k_next           = '0;
                    state_next       = S_GCLOSE;
                end
                else if (last_p)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end

            S_GCLOSE:
            begin
                u_op     = OP_CLOSE;
                u_mat_in = clo_reg;
                u_col    = k_reg;
                clo_next = u_mat_out;
                if (k_reg == UW'(USERS - 1))
                begin
                    state_next = S_GDIAG;
                end
                else
                begin
                    k_next = k_reg + UW'(1);
                end
            end

            S_GDIAG:
            begin
                u_op     = OP_DIAG;
                u_mat_in = clo_reg;
                if (u_flag)
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else if (last_p)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = p_reg + PW'(1);
                    state_next = S_GADD;
                end
            end

            // visit (target, privilege) pairs, targets outer
            S_REDGE:
            begin
                u_op  = OP_EDGE;
                u_col = t_reg;
                if (tgts_reg[t_reg] && privs_reg[p_reg] && u_flag)
                begin
                    work_next[p_reg] = u_mat_out;
                    pend_next        = USERS'(1) << t_reg;
                    state_next       = S_RCASC;
                end
                else if (tgts_reg[t_reg] && privs_reg[p_reg]
                         && action_reg == ACT_REVOKE)
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else if (last_p)
                begin
                    p_next = '0;
                    if (last_t)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        t_next = t_reg + UW'(1);
                    end
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end

            S_RCASC:
            begin
                if (pend_reg != '0)
                begin
                    u_op             = OP_CASC;
                    work_next[p_reg] = u_mat_out;
                    pend_next        = u_pend_out;
                end
                else if (last_p)
                begin
                    p_next = '0;
                    if (last_t)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        t_next     = t_reg + UW'(1);
                        state_next = S_REDGE;
                    end
                end
                else
                begin
                    p_next     = p_reg + PW'(1);
                    state_next = S_REDGE;
                end
            end

            // commit working copy on success
            S_DONE:
            begin
                if (ok_reg)
                begin
                    grant_next = work_reg;
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Owner register
    always_comb
    begin
        owner_next = cfg_we ? owner_user : owner_reg;
    end

    // Control state and grant matrices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            owner_reg <= '0;
            grant_reg <= '0;
            ok_reg    <= 1'b1;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            owner_reg <= owner_next;
            grant_reg <= grant_next;
            ok_reg    <= ok_next;
            held_reg  <= held_next;
        end
    end

    // Working data
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        clo_reg    <= clo_next;
        action_reg <= action_next;
        actor_reg  <= actor_next;
        privs_reg  <= privs_next;
        tgts_reg   <= tgts_next;
        p_reg      <= p_next;
        t_reg      <= t_next;
        k_reg      <= k_next;
        pend_reg   <= pend_next;
    end

    // Outputs
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign success   = ok_reg;
    assign held_mask = 4'(held_reg);

    // Checks
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after done");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |=> $stable(grant_reg))
        else $error("failed transaction changed grants");

    a_check_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done && action_reg == ACT_CHECK) |=> $stable(grant_reg))
        else $error("check changed grants");

    a_held_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (done && held_mask != 4'd0) |-> (action_reg == ACT_CHECK))
        else $error("held mask reported for non-check action");

endmodule

[rtl/pgge_mat_unit.sv]
// ----------------------------------------------------------------------------
// pgge_mat_unit
// Shared combinational matrix unit. Works on one USERS x USERS grant matrix
// (row = grantor, bit = grantee) and performs one step selected by op.
// ----------------------------------------------------------------------------
module pgge_mat_unit
    import pgge_pkg::*;
#(
    parameter int USERS = 4
)
(
    input  op_t                                op,
    input  logic [USERS-1:0][USERS-1:0]        mat_in,
    input  logic [$clog2(USERS)-1:0]           row_sel,
    input  logic [$clog2(USERS)-1:0]           col_sel,
    input  logic [USERS-1:0]                   mask,
    input  logic [USERS-1:0]                   pending_in,
    output logic [USERS-1:0][USERS-1:0]        mat_out,
    output logic [USERS-1:0]                   pending_out,
    output logic                               flag
);

    localparam int UW = $clog2(USERS);

    logic [UW-1:0]                 casc_u;
    logic [USERS-1:0]              casc_row;
    logic [USERS-1:0][USERS-1:0]   casc_mat;
    logic [USERS-1:0]              casc_col_any;
    logic                          col_flag;
    logic                          diag_flag;
    logic [USERS-1:0][USERS-1:0]   close_mat;

    // Column test on the selected grantee
    always_comb
    begin
        col_flag = 1'b0;
        for (int j = 0; j < USERS; j++)
        begin
            col_flag = col_flag | mat_in[j][col_sel];
        end
    end

    // Diagonal test after closure
    always_comb
    begin
        diag_flag = 1'b0;
        for (int i = 0; i < USERS; i++)
        begin
            diag_flag = diag_flag | mat_in[i][i];
        end
    end

    // One Warshall pass; the pivot row itself cannot change within a pass
    always_comb
    begin
        for (int i = 0; i < USERS; i++)
        begin
            if (mat_in[i][col_sel])
            begin
                close_mat[i] = mat_in[i] | mat_in[col_sel];
            end
            else
            begin
                close_mat[i] = mat_in[i];
            end
        end
    end

    // Cascade step: lowest pending user loses its outgoing grants,
    // grantees left with no grantor become pending
    always_comb
    begin
        casc_u = '0;
        for (int i = USERS - 1; i >= 0; i--)
        begin
            if (pending_in[i])
            begin
                casc_u = UW'(i);
            end
        end
        casc_row         = mat_in[casc_u];
        casc_mat         = mat_in;
        casc_mat[casc_u] = '0;
        for (int i = 0; i < USERS; i++)
        begin
            casc_col_any[i] = 1'b0;
            for (int j = 0; j < USERS; j++)
            begin
                casc_col_any[i] = casc_col_any[i] | casc_mat[j][i];
            end
        end
    end

    // Operation select
    always_comb
    begin
        mat_out     = mat_in;
        pending_out = pending_in;
        flag        = 1'b0;
        case (op)
            OP_COL:
            begin
                flag = col_flag;
            end
            OP_ADD:
            begin
                mat_out[row_sel] = mat_in[row_sel] | mask;
            end
            OP_CLOSE:
            begin
                mat_out = close_mat;
            end
            OP_DIAG:
            begin
                flag = diag_flag;
            end
            OP_EDGE:
            begin
                flag                      = mat_in[row_sel][col_sel];
                mat_out[row_sel][col_sel] = 1'b0;
            end
            OP_CASC:
            begin
                mat_out     = casc_mat;
                pending_out = (pending_in & ~(USERS'(1) << casc_u))
                            | (casc_row & ~casc_col_any);
            end
            default:
            begin
                mat_out = mat_in;
            end
        endcase
    end

endmodule
